>>> rtl/core/number_property_classifier_top_defines.svh
// Assertion macros shared by the classifier RTL.
// Each macro expects signals named aclk and aresetn in the including module.
`ifndef NUMBER_PROPERTY_CLASSIFIER_TOP_DEFINES_SVH
`define NUMBER_PROPERTY_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define NPC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/npc_pkg.sv
// Shared types and constants for the number property classifier.
// No dependencies.
package npc_pkg;

    // Default width of the value to classify
    localparam int NPC_VALUE_BITS = 16;

    // Prime factor counters saturate here; a sphenic number needs exactly three
    localparam int          NPC_CNT_BITS      = 3;
    localparam logic [2:0]  NPC_CNT_SAT       = 3'd4;
    localparam logic [2:0]  NPC_SPHENIC_COUNT = 3'd3;

    // Result flags, perfect in the lowest bit
    typedef struct packed {
        logic sphenic;
        logic square;
        logic prime;
        logic perfect;
    } npc_flags_t;

    localparam int NPC_FLAG_BITS = $bits(npc_flags_t);
    localparam int NPC_OUT_BITS  = ((NPC_FLAG_BITS + 7) / 8) * 8;

endpackage

>>> rtl/core/npc_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing but its parameter.
module npc_sdiv #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int CntW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;

    // Trial subtract of the divisor from the partial remainder shifted by one bit
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]} - {1'b0, dvs_reg};

    // Shift in one dividend bit per cycle, keep the difference when it does not borrow
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CntW'(VALUE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[VALUE_BITS]) begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[VALUE_BITS-2:0], quo_reg[VALUE_BITS-1]};
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/npc_ctrl.sv
// Trial division sequencer: steps the divisor, gathers divisor sum and factor counts.
// Depends on npc_pkg, npc_sdiv and the assertion macro header.
`include "number_property_classifier_top_defines.svh"

module npc_ctrl
    import npc_pkg::*;
#(
    parameter int VALUE_BITS = NPC_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  in_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output npc_flags_t            res_flags
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   n_reg, n_next;
    logic [VALUE_BITS-1:0]   m_reg, m_next;
    logic [VALUE_BITS-1:0]   d_reg, d_next;
    logic [VALUE_BITS-1:0]   half_reg, half_next;
    logic [VALUE_BITS-1:0]   sum_reg, sum_next;
    logic                    over_reg, over_next;
    logic                    found_reg, found_next;
    logic                    square_reg, square_next;
    logic                    rep_reg, rep_next;
    logic [NPC_CNT_BITS-1:0] tot_reg, tot_next;
    logic [NPC_CNT_BITS-1:0] dist_reg, dist_next;

    logic                    div_start;
    logic                    n_done;
    logic                    m_done;
    logic [VALUE_BITS-1:0]   n_quo, n_rem;
    logic [VALUE_BITS-1:0]   m_quo, m_rem;
    logic [VALUE_BITS:0]     sum_add;
    logic                    n_div;
    logic                    m_div;
    logic                    big_enough;

    // Divide the number and the unfactored residue by the same trial divisor
    assign div_start = (state_reg == S_LAUNCH);

    npc_sdiv #(.VALUE_BITS(VALUE_BITS)) u_div_n (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (n_done),
        .quotient  (n_quo),
        .remainder (n_rem)
    );

    npc_sdiv #(.VALUE_BITS(VALUE_BITS)) u_div_m (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (m_reg),
        .divisor   (d_reg),
        .done      (m_done),
        .quotient  (m_quo),
        .remainder (m_rem)
    );

    // A repeat pass on the same divisor only strips the residue, never counts n again
    assign sum_add = {1'b0, sum_reg} + {1'b0, d_reg};
    assign n_div   = (n_rem == '0) && !rep_reg;
    assign m_div   = (d_reg != VALUE_BITS'(1)) && (m_rem == '0);

    // Sequence the trial divisors from one up to half the number
    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        d_next      = d_reg;
        half_next   = half_reg;
        sum_next    = sum_reg;
        over_next   = over_reg;
        found_next  = found_reg;
        square_next = square_reg;
        rep_next    = rep_reg;
        tot_next    = tot_reg;
        dist_next   = dist_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    n_next      = in_value;
                    m_next      = in_value;
                    d_next      = VALUE_BITS'(1);
                    half_next   = in_value >> 1;
                    sum_next    = '0;
                    over_next   = 1'b0;
                    found_next  = 1'b0;
                    square_next = (in_value == VALUE_BITS'(1));
                    rep_next    = 1'b0;
                    tot_next    = '0;
                    dist_next   = '0;
                    // Zero and one have no trial divisors at all
                    state_next  = ((in_value >> 1) == '0) ? S_DONE : S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (n_done && m_done) begin
                    if (n_div) begin
                        if (sum_add > {1'b0, n_reg}) begin
                            over_next = 1'b1;
                        end else begin
                            sum_next = sum_add[VALUE_BITS-1:0];
                        end
                        if (d_reg != VALUE_BITS'(1)) begin
                            found_next = 1'b1;
                        end
                        if (n_quo == d_reg) begin
                            square_next = 1'b1;
                        end
                    end
                    if (m_div) begin
                        // Smallest factor of the residue is prime: strip it, retry
                        m_next   = m_quo;
                        rep_next = 1'b1;
                        if (tot_reg != NPC_CNT_SAT) begin
                            tot_next = tot_reg + NPC_CNT_BITS'(1);
                        end
                        if (!rep_reg && (dist_reg != NPC_CNT_SAT)) begin
                            dist_next = dist_reg + NPC_CNT_BITS'(1);
                        end
                        state_next = S_LAUNCH;
                    end else begin
                        rep_next = 1'b0;
                        if (d_reg == half_reg) begin
                            state_next = S_DONE;
                        end else begin
                            d_next     = d_reg + VALUE_BITS'(1);
                            state_next = S_LAUNCH;
                        end
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg      <= n_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        half_reg   <= half_next;
        sum_reg    <= sum_next;
        over_reg   <= over_next;
        found_reg  <= found_next;
        square_reg <= square_next;
        rep_reg    <= rep_next;
        tot_reg    <= tot_next;
        dist_reg   <= dist_next;
    end

    // Form the flags from the gathered totals
    assign big_enough        = (n_reg > VALUE_BITS'(1));
    assign res_flags.perfect = big_enough && !over_reg && (sum_reg == n_reg);
    assign res_flags.prime   = big_enough && !found_reg;
    assign res_flags.square  = square_reg;
    assign res_flags.sphenic = (tot_reg == NPC_SPHENIC_COUNT) &&
                               (dist_reg == NPC_SPHENIC_COUNT);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    `NPC_ASSERT_IMPL(a_divisor_range, (state_reg == S_LAUNCH || state_reg == S_WAIT), (d_reg != '0 && d_reg <= half_reg), "trial divisor out of range")
    `NPC_ASSERT_IMPL(a_count_order, (state_reg != S_IDLE), (dist_reg <= tot_reg), "distinct factor count above total")
    `NPC_ASSERT_IMPL(a_prime_sphenic, res_valid, !(res_flags.prime && res_flags.sphenic), "prime and sphenic both set")
    `NPC_ASSERT_NEXT(a_busy_after_take, (in_valid && in_ready), !in_ready, "ready stayed high after a beat")

endmodule

>>> rtl/core/number_property_classifier_top.sv
// Top level of the number property classifier: stream ports and result register.
// Depends on npc_pkg, npc_ctrl and npc_sdiv.
//
//  channel | dir | tdata fields (lowest bit first)              | tuser | tlast
//  s_      | in  | num_value                                    | -     | -
//  m_      | out | perfect, prime, square, sphenic, zero pad    | -     | -
//
// Each trial divisor d = 1 .. n/2 takes one launch and one pass of the bit-serial dividers,
// plus one more pass for each prime factor stripped.
// Zero and one skip the trial divisors and go straight to the result.
// Reset (aresetn low, synchronous) empties the result register and returns to idle.
// A held result register does not stop the next beat being taken; a finished result
// waits in the sequencer only while the result register is still full.
module number_property_classifier_top
    import npc_pkg::*;
#(
    parameter int VALUE_BITS = NPC_VALUE_BITS,
    localparam int InWidth   = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [InWidth-1:0]      s_tdata,   // num_value, zero pad
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [NPC_OUT_BITS-1:0] m_tdata    // perfect, prime, square, sphenic, zero pad
);

    logic       res_valid;
    logic       res_ready;
    npc_flags_t res_flags;
    logic       out_valid_reg, out_valid_next;
    npc_flags_t out_flags_reg, out_flags_next;

    npc_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .in_ready  (s_tready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_flags (res_flags)
    );

    // Load the result register when it is empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_flags_next = out_flags_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_flags_next = res_flags;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_flags_reg <= out_flags_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(NPC_OUT_BITS - NPC_FLAG_BITS){1'b0}}, out_flags_reg};

endmodule

>>> test/tb_number_property_classifier_top.sv
// Self-checking testbench for number_property_classifier_top: a directed table, then random
// values, with a scoreboard of predicted flags. Depends on npc_pkg and the classifier RTL.
`timescale 1ns / 100ps

module tb_number_property_classifier_top;
    import npc_pkg::*;

    localparam int VALUE_BITS   = NPC_VALUE_BITS;
    localparam int IN_BITS      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_AT      = 30;     // result count at which the sink holds off
    localparam int HOLD_CYCLES  = 20000;
    localparam int DRAIN_CYCLES = 50;

    // Flag patterns, bit order sphenic, square, prime, perfect
    localparam npc_flags_t FL_NONE    = npc_flags_t'(4'b0000);
    localparam npc_flags_t FL_PERFECT = npc_flags_t'(4'b0001);
    localparam npc_flags_t FL_PRIME   = npc_flags_t'(4'b0010);
    localparam npc_flags_t FL_SQUARE  = npc_flags_t'(4'b0100);
    localparam npc_flags_t FL_SPHENIC = npc_flags_t'(4'b1000);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  typed;   // flags below are used as they stand
        npc_flags_t            flags;
    } probe_row_t;

    // Directed values: zero, one, small primes, squares, perfect and sphenic numbers
    localparam probe_row_t PROBES [0:24] = '{
        '{16'd0,     1'b1, FL_NONE},
        '{16'd1,     1'b1, FL_SQUARE},
        '{16'd2,     1'b1, FL_PRIME},
        '{16'd3,     1'b1, FL_PRIME},
        '{16'd4,     1'b1, FL_SQUARE},
        '{16'd5,     1'b0, FL_NONE},
        '{16'd6,     1'b1, FL_PERFECT},
        '{16'd7,     1'b0, FL_NONE},
        '{16'd8,     1'b0, FL_NONE},
        '{16'd9,     1'b0, FL_NONE},
        '{16'd12,    1'b0, FL_NONE},
        '{16'd25,    1'b0, FL_NONE},
        '{16'd28,    1'b1, FL_PERFECT},
        '{16'd30,    1'b1, FL_SPHENIC},
        '{16'd36,    1'b0, FL_NONE},
        '{16'd42,    1'b0, FL_NONE},
        '{16'd60,    1'b0, FL_NONE},
        '{16'd64,    1'b0, FL_NONE},
        '{16'd66,    1'b0, FL_NONE},
        '{16'd97,    1'b0, FL_NONE},
        '{16'd105,   1'b0, FL_NONE},
        '{16'd210,   1'b0, FL_NONE},
        '{16'd496,   1'b0, FL_NONE},
        '{16'd8128,  1'b0, FL_NONE},
        '{16'd65535, 1'b1, FL_NONE}
    };

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_BITS-1:0]      s_tdata  = '0;    // num_value, zero pad
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [NPC_OUT_BITS-1:0] m_tdata;          // perfect, prime, square, sphenic, zero pad

    npc_flags_t flags_due [$];
    int         flag_errors   = 0;
    int         results_taken = 0;

    number_property_classifier_top #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Hard stop if the block hangs
    initial begin
        #160_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic has_no_factor(input int unsigned n);
        int unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Trial division over the proper divisors, as the block does it
    function automatic npc_flags_t classify_number(input logic [VALUE_BITS-1:0] v);
        npc_flags_t         f;
        int unsigned        n;
        int unsigned        d;
        int unsigned        div_sum;
        int unsigned        prime_cnt;
        longint unsigned    prime_prod;
        f          = FL_NONE;
        n          = v;
        div_sum    = 0;
        prime_cnt  = 0;
        prime_prod = 1;
        if (n == 0)
            return f;
        for (d = 1; d <= n / 2; d++) begin
            if (n % d == 0) begin
                div_sum += d;
                if (d >= 2 && has_no_factor(d)) begin
                    prime_cnt++;
                    if (prime_cnt <= 3)
                        prime_prod *= d;
                end
            end
        end
        f.perfect = (div_sum == n);
        f.prime   = has_no_factor(n);
        for (d = 1; d * d <= n; d++)
            if (d * d == n)
                f.square = 1'b1;
        f.sphenic = (prime_cnt == 3) && (prime_prod == n);
        return f;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Offer one value and log its expected flags once the beat is taken
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input logic typed,
                               input npc_flags_t typed_flags, input bit steady);
        int unsigned gap;
        gap = steady ? 0 : idle_cycles();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        flags_due.push_back(typed ? typed_flags : classify_number(v));
    endtask

    task automatic compare_flag(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            flag_errors++;
        end
    endtask

    // Check every result beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        npc_flags_t got;
        npc_flags_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = npc_flags_t'(m_tdata[NPC_FLAG_BITS-1:0]);
            if (flags_due.size() == 0) begin
                $error("result beat with no value outstanding: flags %b", got);
                flag_errors++;
            end else begin
                want = flags_due.pop_front();
                compare_flag("perfect_flag", want.perfect, got.perfect);
                compare_flag("prime_flag",   want.prime,   got.prime);
                compare_flag("square_flag",  want.square,  got.square);
                compare_flag("sphenic_flag", want.sphenic, got.sphenic);
            end
        end
    end

    // Result sink: random stalls, one long hold-off, and a stretch with none
    initial begin : result_sink
        int unsigned stall;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (results_taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if (results_taken >= 60 && results_taken < 80)
                stall = 0;
            else
                stall = idle_cycles();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            results_taken++;
        end
    end

    // Reset, directed table, random values, then drain
    initial begin : stimulus
        int unsigned           i;
        int unsigned           r;
        logic [VALUE_BITS-1:0] v;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < $size(PROBES); i++)
            offer_value(PROBES[i].value, PROBES[i].typed, PROBES[i].flags, 1'b0);

        // Keep values small so that trial division stays short; a few go wider
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                v = $urandom_range(0, 1);
            else if (r < 88)
                v = $urandom_range(2, 255);
            else
                v = $urandom_range(256, 2047);
            offer_value(v, 1'b0, FL_NONE, (i >= 40 && i < 60));
        end
        s_tvalid <= 1'b0;

        while (flags_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (flag_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
